// File: design/md5_pkg.sv
// shared types, constants and round tables for the md5 digest block
// no dependencies; imported by md5_ucode, md5_core and the top level
package md5_pkg;

  localparam logic [31:0] IV_A      = 32'h67452301;
  localparam logic [31:0] IV_B      = 32'hefcdab89;
  localparam logic [31:0] IV_C      = 32'h98badcfe;
  localparam logic [31:0] IV_D      = 32'h10325476;
  localparam logic [7:0]  PAD_MARK  = 8'h80;
  localparam logic [5:0]  BLOCK_MASK = 6'h3f;
  localparam logic [5:0]  LAST_ROUND = 6'd63;

  // microprogram addresses
  typedef enum logic [3:0] {
    ST_WAIT, ST_PREP, ST_ROUND, ST_FOLD, ST_PADSEL,
    ST_AFTER, ST_EMIT, ST_SETLAST, ST_CHKEOM
  } step_t;

  typedef enum logic [2:0] {
    OP_WAIT, OP_PREP, OP_ROUND, OP_FOLD, OP_PADSEL, OP_SETLAST, OP_EMIT, OP_NOP
  } op_t;

  typedef enum logic [2:0] {
    C_ALWAYS, C_DISPATCH, C_LAST, C_FINAL, C_PADFIRST, C_EOM, C_OUT_TAKEN
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t tgt_t;
    step_t tgt_f;
  } uword_t;

  typedef struct packed {
    op_t  op;
    logic accept;
    logic out_taken;
  } ctrl_t;

  typedef struct packed {
    logic hit_full;
    logic hit_eom;
    logic last;
    logic final_blk;
    logic pad_first;
    logic eom;
  } stat_t;

  typedef enum logic [1:0] {
    MODE_FULL, MODE_PAD_ONLY, MODE_PAD_FIRST, MODE_PAD_LAST
  } mode_t;

  typedef enum logic [1:0] {
    BSEL_DATA, BSEL_MARK, BSEL_ZERO
  } bsel_t;

  function automatic logic [31:0] md5_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] md5_rot(input logic [1:0] rnd, input logic [1:0] j);
    logic [4:0] s;
    case ({rnd, j})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  default: s = 5'd21;
    endcase
    return s;
  endfunction

  // message word index used by step i
  function automatic logic [3:0] md5_g(input logic [5:0] i);
    logic [3:0] x;
    logic [3:0] g;
    x = i[3:0];
    case (i[5:4])
      2'd0:    g = x;
      2'd1:    g = x + (x << 2) + 4'd1;
      2'd2:    g = x + (x << 1) + 4'd5;
      default: g = (x << 3) - x;
    endcase
    return g;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] w;
    w = {v, v} << s;
    return w[63:32];
  endfunction

endpackage

// File: design/md5_message_digest_top.sv
// md5 digest, one message byte per item; an item that does not fill a block is taken in wait
// a byte that fills a block adds prep, rounds at one per cycle, fold, after and chkeom
// close: digest follows padsel, prep, rounds and fold; a mark past byte 55 adds after,
// setlast, prep, rounds, fold; an item whose own byte filled a block compresses it first
// no item is taken while the digest waits; taking it restores the initial chaining words
// synchronous active-low reset: initial chaining words, zero byte count, sequencer at wait
module md5_message_digest_top
  import md5_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word_a,
  output logic [31:0] out_digest_word_b,
  output logic [31:0] out_digest_word_c,
  output logic [31:0] out_digest_word_d
);

  ctrl_t ctrl;
  stat_t stat;

  md5_ucode u_ucode (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  md5_core u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctrl              (ctrl),
    .in_data_byte      (in_data_byte),
    .in_has_byte       (in_has_byte),
    .in_end_of_message (in_end_of_message),
    .stat              (stat),
    .digest_a          (out_digest_word_a),
    .digest_b          (out_digest_word_b),
    .digest_c          (out_digest_word_c),
    .digest_d          (out_digest_word_d)
  );

  assign in_ready  = (ctrl.op == OP_WAIT);
  assign out_valid = (ctrl.op == OP_EMIT);

endmodule

// File: design/md5_ucode.sv
// microcode sequencer: control store, step counter and branch conditions
// depends on md5_pkg; drives md5_core through ctrl_t and reads back stat_t
module md5_ucode
  import md5_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output ctrl_t ctrl
);

  step_t  step_r;
  step_t  step_nxt;
  uword_t uw;
  logic   accept;
  logic   out_taken;

  function automatic uword_t rom(input step_t s);
    uword_t w;
    unique case (s)
      ST_WAIT:    w = '{OP_WAIT,    C_DISPATCH,  ST_PREP,    ST_PADSEL};
      ST_PREP:    w = '{OP_PREP,    C_ALWAYS,    ST_ROUND,   ST_ROUND};
      ST_ROUND:   w = '{OP_ROUND,   C_LAST,      ST_FOLD,    ST_ROUND};
      ST_FOLD:    w = '{OP_FOLD,    C_FINAL,     ST_EMIT,    ST_AFTER};
      ST_PADSEL:  w = '{OP_PADSEL,  C_ALWAYS,    ST_PREP,    ST_PREP};
      ST_AFTER:   w = '{OP_NOP,     C_PADFIRST,  ST_SETLAST, ST_CHKEOM};
      ST_SETLAST: w = '{OP_SETLAST, C_ALWAYS,    ST_PREP,    ST_PREP};
      ST_CHKEOM:  w = '{OP_NOP,     C_EOM,       ST_PADSEL,  ST_WAIT};
      ST_EMIT:    w = '{OP_EMIT,    C_OUT_TAKEN, ST_WAIT,    ST_EMIT};
      default:    w = '{OP_NOP,     C_ALWAYS,    ST_WAIT,    ST_WAIT};
    endcase
    return w;
  endfunction

  always_comb begin
    uw        = rom(step_r);
    accept    = in_valid && (uw.op == OP_WAIT);
    out_taken = out_ready && (uw.op == OP_EMIT);
    unique case (uw.cond)
      C_ALWAYS:    step_nxt = uw.tgt_t;
      // full block goes to compression, a close that does not fill a block goes to padding
      C_DISPATCH: begin
        if (accept && stat.hit_full) begin
          step_nxt = uw.tgt_t;
        end else if (accept && stat.hit_eom) begin
          step_nxt = uw.tgt_f;
        end else begin
          step_nxt = step_r;
        end
      end
      C_LAST:      step_nxt = stat.last      ? uw.tgt_t : uw.tgt_f;
      C_FINAL:     step_nxt = stat.final_blk ? uw.tgt_t : uw.tgt_f;
      C_PADFIRST:  step_nxt = stat.pad_first ? uw.tgt_t : uw.tgt_f;
      C_EOM:       step_nxt = stat.eom       ? uw.tgt_t : uw.tgt_f;
      C_OUT_TAKEN: step_nxt = out_taken      ? uw.tgt_t : uw.tgt_f;
      default:     step_nxt = ST_WAIT;
    endcase
    ctrl = '{uw.op, accept, out_taken};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// File: design/md5_core.sv
// md5 datapath: block store, padding mux, round unit, chaining words and byte count
// depends on md5_pkg; steered by md5_ucode through ctrl_t
module md5_core
  import md5_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  ctrl_t       ctrl,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  output stat_t       stat,
  output logic [31:0] digest_a,
  output logic [31:0] digest_b,
  output logic [31:0] digest_c,
  output logic [31:0] digest_d
);

  logic [31:0] cha_r, chb_r, chc_r, chd_r;
  logic [31:0] wa_r, wb_r, wc_r, wd_r;
  logic [63:0] cnt_r;
  logic [5:0]  rnd_r;
  mode_t       mode_r;
  logic        eom_r;

  logic [31:0] mem [16];
  logic [31:0] rd_r;
  bsel_t       bsel_r [4];
  bsel_t       bsel_nxt [4];
  logic        len_use_r, len_use_nxt;
  logic [31:0] lw_r, lw_nxt;
  logic [31:0] k_r;

  logic [5:0]  used;
  logic [5:0]  rd_idx;
  logic [3:0]  rd_addr;
  logic [6:0]  limit;
  logic        mark_en;
  logic        len_en;
  logic [63:0] bit_len;
  logic        rd_en;

  logic [31:0] w_word;
  logic [31:0] f;
  logic [31:0] t;
  logic [31:0] wb_nxt;

  assign used    = cnt_r[5:0];
  assign bit_len = {cnt_r[60:0], 3'b000};
  assign rd_idx  = (ctrl.op == OP_PREP) ? 6'd0 : rnd_r + 6'd1;
  assign rd_addr = md5_g(rd_idx);
  assign rd_en   = (ctrl.op == OP_PREP) || (ctrl.op == OP_ROUND);

  // which bytes of the word come from the store, which are the pad mark or zero
  always_comb begin
    logic [5:0] p;
    case (mode_r)
      MODE_FULL:      limit = 7'd64;
      MODE_PAD_ONLY,
      MODE_PAD_FIRST: limit = {1'b0, used};
      default:        limit = 7'd0;
    endcase
    mark_en = (mode_r == MODE_PAD_ONLY) || (mode_r == MODE_PAD_FIRST);
    len_en  = (mode_r == MODE_PAD_ONLY) || (mode_r == MODE_PAD_LAST);
    for (int k = 0; k < 4; k++) begin
      p = {rd_addr, 2'(k)};
      if ({1'b0, p} < limit) begin
        bsel_nxt[k] = BSEL_DATA;
      end else if (mark_en && (p == used)) begin
        bsel_nxt[k] = BSEL_MARK;
      end else begin
        bsel_nxt[k] = BSEL_ZERO;
      end
    end
    len_use_nxt = len_en && (rd_addr[3:1] == 3'b111);
    lw_nxt      = rd_addr[0] ? bit_len[63:32] : bit_len[31:0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept && in_has_byte) begin
      mem[used[5:2]][{used[1:0], 3'b000} +: 8] <= in_data_byte;
    end
    if (rd_en) begin
      rd_r      <= mem[rd_addr];
      bsel_r    <= bsel_nxt;
      len_use_r <= len_use_nxt;
      lw_r      <= lw_nxt;
      k_r       <= md5_k(rd_idx);
    end
  end

  // one md5 step per cycle
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      case (bsel_r[k])
        BSEL_DATA: w_word[k*8 +: 8] = rd_r[k*8 +: 8];
        BSEL_MARK: w_word[k*8 +: 8] = PAD_MARK;
        default:   w_word[k*8 +: 8] = 8'h00;
      endcase
    end
    if (len_use_r) begin
      w_word = lw_r;
    end
    case (rnd_r[5:4])
      2'd0:    f = wd_r ^ (wb_r & (wc_r ^ wd_r));
      2'd1:    f = wc_r ^ (wd_r & (wb_r ^ wc_r));
      2'd2:    f = wb_r ^ wc_r ^ wd_r;
      default: f = wc_r ^ (wb_r | ~wd_r);
    endcase
    t      = wa_r + f + w_word + k_r;
    wb_nxt = wb_r + rotl32(t, md5_rot(rnd_r[5:4], rnd_r[1:0]));
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_PREP) begin
      wa_r <= cha_r;
      wb_r <= chb_r;
      wc_r <= chc_r;
      wd_r <= chd_r;
    end else if (ctrl.op == OP_ROUND) begin
      wa_r <= wd_r;
      wd_r <= wc_r;
      wc_r <= wb_r;
      wb_r <= wb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cha_r  <= IV_A;
      chb_r  <= IV_B;
      chc_r  <= IV_C;
      chd_r  <= IV_D;
      cnt_r  <= 64'd0;
      rnd_r  <= 6'd0;
      mode_r <= MODE_FULL;
      eom_r  <= 1'b0;
    end else begin
      case (ctrl.op)
        OP_WAIT: begin
          if (ctrl.accept) begin
            eom_r <= in_end_of_message;
            if (in_has_byte) begin
              cnt_r <= cnt_r + 64'd1;
            end
            if (stat.hit_full) begin
              mode_r <= MODE_FULL;
            end
          end
        end
        OP_PREP:  rnd_r <= 6'd0;
        OP_ROUND: rnd_r <= rnd_r + 6'd1;
        OP_FOLD: begin
          cha_r <= cha_r + wa_r;
          chb_r <= chb_r + wb_r;
          chc_r <= chc_r + wc_r;
          chd_r <= chd_r + wd_r;
        end
        // mark lands past byte 55: length needs a second block
        OP_PADSEL: mode_r <= (used[5:3] == 3'b111) ? MODE_PAD_FIRST : MODE_PAD_ONLY;
        OP_SETLAST: mode_r <= MODE_PAD_LAST;
        OP_EMIT: begin
          if (ctrl.out_taken) begin
            cha_r <= IV_A;
            chb_r <= IV_B;
            chc_r <= IV_C;
            chd_r <= IV_D;
            cnt_r <= 64'd0;
          end
        end
        default: ;
      endcase
    end
  end

  assign stat = '{
    hit_full:  in_has_byte && (used == BLOCK_MASK),
    hit_eom:   in_end_of_message,
    last:      rnd_r == LAST_ROUND,
    final_blk: (mode_r == MODE_PAD_ONLY) || (mode_r == MODE_PAD_LAST),
    pad_first: mode_r == MODE_PAD_FIRST,
    eom:       eom_r
  };

  assign digest_a = cha_r;
  assign digest_b = chb_r;
  assign digest_c = chc_r;
  assign digest_d = chd_r;

endmodule

// File: design/md5_checker.sv
// port-level checks for md5_message_digest_top, bound to the top level
// no package dependency; sees only the top level's ports
module md5_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_end_of_message,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_digest_word_a,
  input logic [31:0] out_digest_word_b,
  input logic [31:0] out_digest_word_c,
  input logic [31:0] out_digest_word_d
);

  // a waiting digest holds
  a_digest_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digest_word_a) &&
      $stable(out_digest_word_b) && $stable(out_digest_word_c) &&
      $stable(out_digest_word_d))
    else $error("digest changed while stalled");

  // no item is taken while a digest is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while digest pending");

  // closing a message needs the compression rounds first
  a_close_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_end_of_message |=> !out_valid ##1 !out_valid)
    else $error("digest appeared too early");

  // a taken digest is not repeated and the input is ready again
  a_single_digest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid && in_ready)
    else $error("digest repeated after it was taken");

endmodule

bind md5_message_digest_top md5_checker u_md5_checker (.*);
